// ===== design/bhd_pkg.sv =====
package bhd_pkg;

    localparam int PIX_W = 8;
    localparam int CFG_W = 12;
    localparam int CFG_INDEX_W = 1;
    localparam int DEF_MAX_WIDTH = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int QUEUE_DEPTH = 4;
    localparam int LINE_BANKS = 3;
    localparam int TAPS = 4;
    localparam int V_W = 13;
    localparam int SUM_W = 17;
    localparam int SCALE_SHIFT = 6;

    localparam logic [CFG_W-1:0] RESET_SRC_WIDTH = 12'd1920;
    localparam logic [CFG_W-1:0] RESET_SRC_HEIGHT = 12'd1080;

    localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 1'b1;

    typedef logic [1:0] row_src_t;

    localparam row_src_t ROW_SRC_BANK0 = 2'd0;
    localparam row_src_t ROW_SRC_BANK1 = 2'd1;
    localparam row_src_t ROW_SRC_BANK2 = 2'd2;
    localparam row_src_t ROW_SRC_PIXEL = 2'd3;

    typedef enum logic [1:0]
    {
        COL_FULL,
        COL_LEFT_EDGE,
        COL_RIGHT_EDGE,
        COL_NARROW
    } col_mode_t;

    typedef struct packed
    {
        logic emit;
        logic row_end;
        logic frame_end;
        logic [1:0] bank;
        col_mode_t col_mode;
        row_src_t [TAPS-1:0] row_src;
        logic [PIX_W-1:0] pixel;
    } cmd_t;

endpackage

// ===== design/bhd_front.sv =====
module bhd_front #(
    parameter int MAX_WIDTH = bhd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bhd_pkg::DEF_MAX_HEIGHT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic [bhd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bhd_pkg::CFG_W-1:0] cfg_data,
    input  logic in_valid,
    input  logic [bhd_pkg::PIX_W-1:0] pixel_in,
    input  logic frame_start,
    output logic in_stall,
    input  logic fifo_full,
    output logic push,
    output bhd_pkg::cmd_t cmd,
    output logic [$clog2(MAX_WIDTH)-1:0] col_addr
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int SWW = $clog2(MAX_WIDTH + 1);
    localparam int SHW = $clog2(MAX_HEIGHT + 1);
    localparam int WTW = (SWW > bhd_pkg::CFG_W) ? SWW : bhd_pkg::CFG_W;
    localparam int HTW = (SHW > bhd_pkg::CFG_W) ? SHW : bhd_pkg::CFG_W;
    localparam int W_CAP = (MAX_WIDTH / 2) * 2;
    localparam int H_CAP = (MAX_HEIGHT / 2) * 2;

    logic [bhd_pkg::CFG_W-1:0] src_width_reg;
    logic [bhd_pkg::CFG_W-1:0] src_height_reg;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [1:0] rmod_reg;
    logic [1:0] rmod_next;

    logic [WTW-1:0] w_tmp;
    logic [HTW-1:0] h_tmp;
    logic [SWW-1:0] w_eff;
    logic [SHW-1:0] h_eff;
    logic [CW-1:0] c;
    logic [RW-1:0] r;
    logic [1:0] rmod;
    logic [SWW-1:0] c_ext;
    logic [SHW-1:0] r_ext;
    logic [SWW-1:0] c_inc;
    logic [SHW-1:0] r_inc;
    logic c_last;
    logic r_last;
    logic col_emit;
    logic row_emit;
    logic [bhd_pkg::TAPS-1:0][1:0] row_delta;

    function automatic bhd_pkg::row_src_t row_bank(input logic [1:0] m, input logic [1:0] d);
        logic [2:0] t;
        begin
            t = {1'b0, m} + 3'd3 - {1'b0, d};
            if (t >= 3'd3)
            begin
                t = t - 3'd3;
            end
            return t[1:0];
        end
    endfunction

    always_comb
    begin
        w_tmp = {src_width_reg[bhd_pkg::CFG_W-1:1], 1'b0};
        if (w_tmp < WTW'(2))
        begin
            w_tmp = WTW'(2);
        end
        if (w_tmp > WTW'(W_CAP))
        begin
            w_tmp = WTW'(W_CAP);
        end
        w_eff = w_tmp[SWW-1:0];

        h_tmp = {src_height_reg[bhd_pkg::CFG_W-1:1], 1'b0};
        if (h_tmp < HTW'(2))
        begin
            h_tmp = HTW'(2);
        end
        if (h_tmp > HTW'(H_CAP))
        begin
            h_tmp = HTW'(H_CAP);
        end
        h_eff = h_tmp[SHW-1:0];
    end

    always_comb
    begin
        if (frame_start || (SWW'(col_reg) >= w_eff))
        begin
            c = '0;
        end
        else
        begin
            c = col_reg;
        end

        if (frame_start || (SHW'(row_reg) >= h_eff))
        begin
            r = '0;
            rmod = 2'd0;
        end
        else
        begin
            r = row_reg;
            rmod = rmod_reg;
        end

        c_ext = SWW'(c);
        r_ext = SHW'(r);
        c_last = (c_ext == w_eff - SWW'(1));
        r_last = (r_ext == h_eff - SHW'(1));
        col_emit = c_last || (!c[0] && (c_ext >= SWW'(2)) && (c_ext <= w_eff - SWW'(2)));
        row_emit = r_last || (!r[0] && (r_ext >= SHW'(2)) && (r_ext <= h_eff - SHW'(2)));
    end

    always_comb
    begin
        cmd.emit = col_emit && row_emit;
        cmd.row_end = c_last;
        cmd.frame_end = c_last && r_last;
        cmd.bank = rmod;
        cmd.pixel = pixel_in;

        if (c_last)
        begin
            cmd.col_mode = (w_eff == SWW'(2)) ? bhd_pkg::COL_NARROW : bhd_pkg::COL_RIGHT_EDGE;
        end
        else if (c_ext == SWW'(2))
        begin
            cmd.col_mode = bhd_pkg::COL_LEFT_EDGE;
        end
        else
        begin
            cmd.col_mode = bhd_pkg::COL_FULL;
        end

        // rows back from the current one, oldest tap first
        if (r_last)
        begin
            if (h_eff == SHW'(2))
            begin
                row_delta = {2'd0, 2'd0, 2'd1, 2'd1};
            end
            else
            begin
                row_delta = {2'd0, 2'd0, 2'd1, 2'd2};
            end
        end
        else if (r_ext == SHW'(2))
        begin
            row_delta = {2'd0, 2'd1, 2'd2, 2'd2};
        end
        else
        begin
            row_delta = {2'd0, 2'd1, 2'd2, 2'd3};
        end

        for (int k = 0; k < bhd_pkg::TAPS; k++)
        begin
            if (row_delta[k] == 2'd0)
            begin
                cmd.row_src[k] = bhd_pkg::ROW_SRC_PIXEL;
            end
            else
            begin
                cmd.row_src[k] = row_bank(rmod, row_delta[k]);
            end
        end
    end

    always_comb
    begin
        c_inc = c_ext + SWW'(1);
        r_inc = r_ext + SHW'(1);
        col_next = c_inc[CW-1:0];
        row_next = r;
        rmod_next = rmod;
        if (c_inc >= w_eff)
        begin
            col_next = '0;
            if (r_inc >= h_eff)
            begin
                row_next = '0;
                rmod_next = 2'd0;
            end
            else
            begin
                row_next = r_inc[RW-1:0];
                rmod_next = (rmod == 2'd2) ? 2'd0 : rmod + 2'd1;
            end
        end
    end

    assign push = in_valid && !fifo_full;
    assign in_stall = fifo_full;
    assign col_addr = c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg <= bhd_pkg::RESET_SRC_WIDTH;
            src_height_reg <= bhd_pkg::RESET_SRC_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bhd_pkg::REG_SRC_WIDTH:
                begin
                    src_width_reg <= cfg_data;
                end
                bhd_pkg::REG_SRC_HEIGHT:
                begin
                    src_height_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            rmod_reg <= 2'd0;
        end
        else if (push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            rmod_reg <= rmod_next;
        end
    end

endmodule

// ===== design/bhd_fifo.sv =====
module bhd_fifo #(
    parameter int DATA_W = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  logic [DATA_W-1:0] push_data,
    input  logic pop,
    output logic [DATA_W-1:0] pop_data,
    output logic full,
    output logic empty
);

    localparam int PW = $clog2(bhd_pkg::QUEUE_DEPTH);
    localparam int NW = $clog2(bhd_pkg::QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [bhd_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;

    assign full = (count_reg == NW'(bhd_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(bhd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(bhd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/bhd_back.sv =====
module bhd_back #(
    parameter int MAX_WIDTH = bhd_pkg::DEF_MAX_WIDTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic pop,
    input  bhd_pkg::cmd_t cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0] col_addr,
    output logic out_valid,
    input  logic out_stall,
    output logic [bhd_pkg::PIX_W-1:0] pixel_out,
    output logic row_end,
    output logic frame_end
);

    localparam int V_W = bhd_pkg::V_W;
    localparam int SUM_W = bhd_pkg::SUM_W;
    localparam int Q_W = SUM_W - 1 - bhd_pkg::SCALE_SHIFT;

    logic en;
    logic [bhd_pkg::PIX_W-1:0] rd_reg [bhd_pkg::LINE_BANKS];

    logic s1_valid_reg;
    bhd_pkg::cmd_t s1_cmd_reg;
    logic [bhd_pkg::PIX_W-1:0] tap_byte [bhd_pkg::TAPS];
    logic [V_W-1:0] mid;
    logic signed [V_W-1:0] v_next;

    logic s2_valid_reg;
    bhd_pkg::cmd_t s2_cmd_reg;
    logic signed [V_W-1:0] win_v_reg [bhd_pkg::TAPS];
    logic [bhd_pkg::PIX_W-1:0] win_c_reg [bhd_pkg::TAPS];
    logic signed [V_W-1:0] v0;
    logic signed [V_W-1:0] v1;
    logic signed [V_W-1:0] v2;
    logic signed [V_W-1:0] v3;
    logic [bhd_pkg::PIX_W-1:0] centre;
    logic signed [SUM_W-1:0] e0;
    logic signed [SUM_W-1:0] e1;
    logic signed [SUM_W-1:0] e2;
    logic signed [SUM_W-1:0] e3;
    logic signed [SUM_W-1:0] pair;
    logic signed [SUM_W-1:0] sum_next;

    logic s3_valid_reg;
    logic s3_emit_reg;
    logic s3_row_end_reg;
    logic s3_frame_end_reg;
    logic signed [SUM_W-1:0] s3_sum_reg;
    logic [bhd_pkg::PIX_W-1:0] s3_centre_reg;
    logic [Q_W-1:0] quot;
    logic [bhd_pkg::PIX_W-1:0] result;

    logic out_valid_reg;
    logic [bhd_pkg::PIX_W-1:0] pixel_out_reg;
    logic row_end_reg;
    logic frame_end_reg;

    assign en = !out_valid_reg || !out_stall;
    assign pop = q_valid && en;

    for (genvar gb = 0; gb < bhd_pkg::LINE_BANKS; gb++)
    begin : g_bank
        logic [bhd_pkg::PIX_W-1:0] line_mem [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (pop && (cmd.bank == 2'(gb)))
            begin
                line_mem[col_addr] <= cmd.pixel;
            end
            if (en)
            begin
                rd_reg[gb] <= line_mem[col_addr];
            end
        end
    end

    // vertical filter of the current column
    always_comb
    begin
        for (int k = 0; k < bhd_pkg::TAPS; k++)
        begin
            case (s1_cmd_reg.row_src[k])
                bhd_pkg::ROW_SRC_BANK0: tap_byte[k] = rd_reg[0];
                bhd_pkg::ROW_SRC_BANK1: tap_byte[k] = rd_reg[1];
                bhd_pkg::ROW_SRC_BANK2: tap_byte[k] = rd_reg[2];
                default: tap_byte[k] = s1_cmd_reg.pixel;
            endcase
        end
        mid = V_W'(tap_byte[1]) + V_W'(tap_byte[2]);
        v_next = (mid << 2) + mid - V_W'(tap_byte[0]) - V_W'(tap_byte[3]);
    end

    // horizontal filter over the column window, newest column at index 0
    always_comb
    begin
        case (s2_cmd_reg.col_mode)
            bhd_pkg::COL_FULL:
            begin
                v0 = win_v_reg[3];
                v1 = win_v_reg[2];
                v2 = win_v_reg[1];
                v3 = win_v_reg[0];
                centre = win_c_reg[2];
            end
            bhd_pkg::COL_LEFT_EDGE:
            begin
                v0 = win_v_reg[2];
                v1 = win_v_reg[2];
                v2 = win_v_reg[1];
                v3 = win_v_reg[0];
                centre = win_c_reg[2];
            end
            bhd_pkg::COL_RIGHT_EDGE:
            begin
                v0 = win_v_reg[2];
                v1 = win_v_reg[1];
                v2 = win_v_reg[0];
                v3 = win_v_reg[0];
                centre = win_c_reg[1];
            end
            default:
            begin
                v0 = win_v_reg[1];
                v1 = win_v_reg[1];
                v2 = win_v_reg[0];
                v3 = win_v_reg[0];
                centre = win_c_reg[1];
            end
        endcase
        e0 = {{(SUM_W - V_W){v0[V_W-1]}}, v0};
        e1 = {{(SUM_W - V_W){v1[V_W-1]}}, v1};
        e2 = {{(SUM_W - V_W){v2[V_W-1]}}, v2};
        e3 = {{(SUM_W - V_W){v3[V_W-1]}}, v3};
        pair = e1 + e2;
        sum_next = (pair <<< 2) + pair - e0 - e3;
    end

    // drop negatives, scale, cap at the centre pixel
    always_comb
    begin
        quot = s3_sum_reg[SUM_W-2:bhd_pkg::SCALE_SHIFT];
        if (s3_sum_reg[SUM_W-1])
        begin
            result = '0;
        end
        else if (quot > Q_W'(s3_centre_reg))
        begin
            result = s3_centre_reg;
        end
        else
        begin
            result = quot[bhd_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg && s3_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cmd_reg <= cmd;
            s2_cmd_reg <= s1_cmd_reg;
            s3_emit_reg <= s2_cmd_reg.emit;
            s3_row_end_reg <= s2_cmd_reg.row_end;
            s3_frame_end_reg <= s2_cmd_reg.frame_end;
            s3_sum_reg <= sum_next;
            s3_centre_reg <= centre;
            pixel_out_reg <= result;
            row_end_reg <= s3_row_end_reg;
            frame_end_reg <= s3_frame_end_reg;
            if (s1_valid_reg)
            begin
                win_v_reg[0] <= v_next;
                win_c_reg[0] <= tap_byte[1];
                for (int k = 1; k < bhd_pkg::TAPS; k++)
                begin
                    win_v_reg[k] <= win_v_reg[k-1];
                    win_c_reg[k] <= win_c_reg[k-1];
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign row_end = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

// ===== design/bicubic_half_downscaler.sv =====
// Bicubic 2:1 downscaler for one 8-bit plane.
// Input channel: in_valid / in_stall carry pixel_in and frame_start, one
// source pixel per request in raster order; frame_start marks pixel (0,0).
// Output channel: out_valid / out_stall carry pixel_out, row_end and
// frame_end in raster order of the half-size plane. Source rows and columns
// that complete no output produce no output request.
// Configuration: cfg_write with cfg_index 0 (src_width) or 1 (src_height); the
// user is to have them written only while the block is idle; the block does not enforce it.
// Throughput: one source pixel per cycle while in_stall is low. The front counts
// positions and classifies each pixel into a 4-entry queue; the back reads three
// line banks, filters vertically, then horizontally over a 4-column window.
// Path: the source pixel that completes a neighborhood passes the queue, then the
// bank read, column window, sum and output registers before its output appears.
// Stall: out_stall holds the whole back pipeline while out_valid is high; the
// queue keeps taking input until it holds 4 requests, then in_stall rises.
// Reset: sizes return to 1920x1080, position counters to (0,0), queue and
// pipeline empty. Line banks are not cleared; no clearing pass is needed.
module bicubic_half_downscaler #(
    parameter int MAX_WIDTH = bhd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bhd_pkg::DEF_MAX_HEIGHT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic [bhd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bhd_pkg::CFG_W-1:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic [bhd_pkg::PIX_W-1:0] pixel_in,
    input  logic frame_start,
    output logic out_valid,
    input  logic out_stall,
    output logic [bhd_pkg::PIX_W-1:0] pixel_out,
    output logic row_end,
    output logic frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int CMD_W = $bits(bhd_pkg::cmd_t);
    localparam int Q_W = CMD_W + CW;

    logic push;
    logic pop;
    logic fifo_full;
    logic fifo_empty;
    bhd_pkg::cmd_t front_cmd;
    bhd_pkg::cmd_t back_cmd;
    logic [CW-1:0] front_col;
    logic [CW-1:0] back_col;
    logic [Q_W-1:0] q_out;

    bhd_front #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .pixel_in(pixel_in),
        .frame_start(frame_start),
        .in_stall(in_stall),
        .fifo_full(fifo_full),
        .push(push),
        .cmd(front_cmd),
        .col_addr(front_col)
    );

    bhd_fifo #(
        .DATA_W(Q_W)
    ) u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_data({front_col, front_cmd}),
        .pop(pop),
        .pop_data(q_out),
        .full(fifo_full),
        .empty(fifo_empty)
    );

    assign back_cmd = q_out[CMD_W-1:0];
    assign back_col = q_out[Q_W-1:CMD_W];

    bhd_back #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_valid(!fifo_empty),
        .pop(pop),
        .cmd(back_cmd),
        .col_addr(back_col),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pixel_out(pixel_out),
        .row_end(row_end),
        .frame_end(frame_end)
    );

    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_full && fifo_empty))
        else $error("queue reports full and empty together");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fifo_empty)
        else $error("back pops an empty queue");

    a_no_instant_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_empty && !push) |=> !fifo_full)
        else $error("queue became full without enough requests");

    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |-> row_end)
        else $error("frame end without row end");

endmodule

// ===== tb/bicubic_half_downscaler_tb.sv =====
module bicubic_half_downscaler_tb;

    localparam int MAX_W = bhd_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H = bhd_pkg::DEF_MAX_HEIGHT;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 1500;
    localparam int CALM_TAIL = 250;
    localparam int EDGE_RUN = 100;

    typedef struct packed
    {
        logic [bhd_pkg::PIX_W-1:0] value;
        logic row_end;
        logic frame_end;
    } out_pixel_t;

    typedef enum int
    {
        PLANE_CLEAN,
        PLANE_CUT,
        PLANE_NO_MARK
    } plane_mode_t;

    typedef enum int
    {
        FILL_RANDOM,
        FILL_EXTREME,
        FILL_RAILS
    } fill_t;

    class half_plane_scoreboard;
        logic [bhd_pkg::PIX_W-1:0] line_bank [bhd_pkg::LINE_BANKS][MAX_W];
        logic [31:0] col_window [3];
        int col_pos;
        int row_pos;
        logic [bhd_pkg::CFG_W-1:0] width_reg;
        logic [bhd_pkg::CFG_W-1:0] height_reg;
        int weight [bhd_pkg::TAPS];
        out_pixel_t due_pixels [$];
        int fails;

        function new();
            foreach (line_bank[b, c])
                line_bank[b][c] = '0;
            foreach (col_window[k])
                col_window[k] = '0;
            col_pos = 0;
            row_pos = 0;
            width_reg = bhd_pkg::RESET_SRC_WIDTH;
            height_reg = bhd_pkg::RESET_SRC_HEIGHT;
            weight = '{-1, 5, 5, -1};
            fails = 0;
        endfunction

        function void flag(string msg);
            $display("ERROR: %s", msg);
            fails++;
        endfunction

        function int clamp_size(logic [bhd_pkg::CFG_W-1:0] reg_v, int maxv);
            int v;
            int m;
            v = int'(reg_v) & ~1;
            m = maxv & ~1;
            if (v < 2)
                v = 2;
            if (v > m)
                v = m;
            return v;
        endfunction

        function int plane_width();
            return clamp_size(width_reg, MAX_W);
        endfunction

        function int plane_height();
            return clamp_size(height_reg, MAX_H);
        endfunction

        function int tap_at(int center, int k, int size);
            int p;
            if (k == 0)
                p = (center >= 1) ? center - 1 : 0;
            else
                p = center + k - 1;
            if (p > size - 1)
                p = size - 1;
            return p;
        endfunction

        function void set_reg(logic [bhd_pkg::CFG_INDEX_W-1:0] idx,
                              logic [bhd_pkg::CFG_W-1:0] val);
            if (idx == bhd_pkg::REG_SRC_WIDTH)
                width_reg = val;
            else
                height_reg = val;
        endfunction

        function void take_pixel(logic [bhd_pkg::PIX_W-1:0] px, logic mark);
            int w;
            int h;
            int c;
            int r;
            int j;
            int i;
            int y;
            int x;
            int d;
            int s;
            int pix_v;
            int centre;
            int res;
            logic [31:0] vec;
            logic [31:0] colv;
            logic row_hit;
            logic col_hit;
            out_pixel_t e;
            w = plane_width();
            h = plane_height();
            vec = '0;
            centre = 0;
            if (mark)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            if (col_pos >= w)
                col_pos = 0;
            if (row_pos >= h)
                row_pos = 0;
            c = col_pos;
            r = row_pos;
            row_hit = (r == h - 1) || (r % 2 == 0 && r >= 2 && r <= h - 2);
            col_hit = (c == w - 1) || (c % 2 == 0 && c >= 2 && c <= w - 2);

            if (row_hit)
            begin
                j = (r == h - 1) ? h / 2 - 1 : (r - 2) / 2;
                for (int k = 0; k < bhd_pkg::TAPS; k++)
                begin
                    y = tap_at(2 * j, k, h);
                    vec[8*k +: 8] = (y == r) ? px : line_bank[y % 3][c];
                end
            end
            line_bank[r % 3][c] = px;

            if (row_hit && col_hit)
            begin
                s = 0;
                i = (c == w - 1) ? w / 2 - 1 : (c - 2) / 2;
                for (int k = 0; k < bhd_pkg::TAPS; k++)
                begin
                    x = tap_at(2 * i, k, w);
                    d = c - x;
                    colv = (d == 0) ? vec : col_window[(d - 1) % 3];
                    for (int m = 0; m < bhd_pkg::TAPS; m++)
                    begin
                        pix_v = int'(colv[8*m +: 8]);
                        s += weight[m] * weight[k] * pix_v;
                    end
                    if (k == 1)
                        centre = int'(colv[15:8]);
                end
                if (s < 0)
                    res = 0;
                else
                begin
                    res = s >>> bhd_pkg::SCALE_SHIFT;
                    if (res > centre)
                        res = centre;
                    if (res > 255)
                        res = 255;
                end
                e.value = res[bhd_pkg::PIX_W-1:0];
                e.row_end = (c == w - 1);
                e.frame_end = (c == w - 1) && (r == h - 1);
                due_pixels.push_back(e);
            end

            col_window[2] = col_window[1];
            col_window[1] = col_window[0];
            col_window[0] = vec;

            col_pos = c + 1;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos = r + 1;
                if (row_pos >= h)
                    row_pos = 0;
            end
        endfunction

        function void check_pixel(logic [bhd_pkg::PIX_W-1:0] px, logic re, logic fe);
            out_pixel_t e;
            if (due_pixels.size() == 0)
            begin
                flag($sformatf("unexpected output pixel %0d row_end %0d frame_end %0d",
                    px, re, fe));
                return;
            end
            e = due_pixels.pop_front();
            if (px !== e.value)
                flag($sformatf("pixel_out %0d, expected %0d", px, e.value));
            if (re !== e.row_end)
                flag($sformatf("row_end %0d, expected %0d", re, e.row_end));
            if (fe !== e.frame_end)
                flag($sformatf("frame_end %0d, expected %0d", fe, e.frame_end));
        endfunction

        function int pending();
            return due_pixels.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [bhd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [bhd_pkg::CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [bhd_pkg::PIX_W-1:0] pixel_in;
    logic frame_start;
    logic out_valid;
    logic out_stall;
    logic [bhd_pkg::PIX_W-1:0] pixel_out;
    logic row_end;
    logic frame_end;

    half_plane_scoreboard sb;
    int sent;
    bit calm;
    bit quiet;

    bicubic_half_downscaler dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pixel_in(pixel_in),
        .frame_start(frame_start),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pixel_out(pixel_out),
        .row_end(row_end),
        .frame_end(frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("bicubic_half_downscaler test failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_pixel(pixel_out, row_end, frame_end);
    end

    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (calm)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(50, 200)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 30)) @(posedge clk);
                if (!calm)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
            end
        end
    end

    task automatic send_pixel(logic [bhd_pkg::PIX_W-1:0] px, logic mark);
        in_valid <= 1'b1;
        pixel_in <= px;
        frame_start <= mark;
        do
            @(posedge clk);
        while (in_stall);
        sb.take_pixel(px, mark);
        sent++;
    endtask

    task automatic pace();
        if (!calm && !quiet && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(logic [bhd_pkg::CFG_W-1:0] w, logic [bhd_pkg::CFG_W-1:0] h);
        cfg_write <= 1'b1;
        cfg_index <= bhd_pkg::REG_SRC_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        sb.set_reg(bhd_pkg::REG_SRC_WIDTH, w);
        cfg_index <= bhd_pkg::REG_SRC_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        sb.set_reg(bhd_pkg::REG_SRC_HEIGHT, h);
        cfg_write <= 1'b0;
    endtask

    task automatic send_run(int count, logic mark, fill_t fill);
        logic [bhd_pkg::PIX_W-1:0] px;
        int v;
        for (int n = 0; n < count; n++)
        begin
            case (fill)
                FILL_EXTREME: v = $urandom_range(0, 1) ? 255 : 0;
                FILL_RAILS: v = $urandom_range(0, 1) ? int'($urandom_range(0, 12))
                                                     : int'($urandom_range(243, 255));
                default: v = int'($urandom_range(0, 255));
            endcase
            px = v[bhd_pkg::PIX_W-1:0];
            pace();
            send_pixel(px, mark && n == 0);
        end
    endtask

    initial
    begin
        int goal;
        int planes;
        int area;
        int count;
        int wpick;
        int hpick;
        logic [bhd_pkg::CFG_W-1:0] wreg;
        logic [bhd_pkg::CFG_W-1:0] hreg;
        plane_mode_t mode;
        fill_t fill;

        sb = new();
        sent = 0;
        calm = 1'b0;
        quiet = 1'b0;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= bhd_pkg::REG_SRC_WIDTH;
        cfg_data <= '0;
        in_valid <= 1'b0;
        pixel_in <= '0;
        frame_start <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // checkerboard of rails: negative sums and centre cap
        set_size(12'd4, 12'd4);
        for (int n = 0; n < 16; n++)
        begin
            pace();
            send_pixel(((n / 4 + n % 4) % 2) ? 8'd255 : 8'd0, n == 0);
        end
        settle();

        // odd and undersized registers, flat planes at both ends of the range
        set_size(12'd3, 12'd1);
        for (int n = 0; n < 4; n++)
            send_pixel(8'd255, n == 0);
        for (int n = 0; n < 4; n++)
            send_pixel(8'd0, n == 0);
        settle();

        // oversized registers
        set_size(12'hFFF, 12'h000);
        send_run(EDGE_RUN, 1'b1, FILL_RANDOM);
        settle();
        set_size(12'h000, 12'hFFF);
        send_run(EDGE_RUN, 1'b1, FILL_RAILS);
        settle();

        // shrink width mid-plane: column restarts, row holds
        set_size(12'd8, 12'd6);
        send_run(29, 1'b1, FILL_RANDOM);
        settle();
        set_size(12'd4, 12'd6);
        send_run(12, 1'b0, FILL_RANDOM);
        settle();

        // shrink height mid-plane: row restarts, column holds
        set_size(12'd8, 12'd8);
        send_run(43, 1'b1, FILL_EXTREME);
        settle();
        set_size(12'd8, 12'd4);
        send_run(29, 1'b0, FILL_RANDOM);

        goal = sent + RANDOM_ITEMS;
        while (sent < goal)
        begin
            settle();
            case ($urandom_range(0, 9))
                0: wpick = int'($urandom_range(0, 1));
                1: wpick = int'($urandom_range(40, 160));
                default: wpick = int'($urandom_range(2, 20));
            endcase
            if (wpick > 20)
                hpick = int'($urandom_range(2, 4));
            else if ($urandom_range(0, 9) == 0)
                hpick = int'($urandom_range(0, 1));
            else
                hpick = int'($urandom_range(2, 14));
            wreg = wpick[bhd_pkg::CFG_W-1:0];
            hreg = hpick[bhd_pkg::CFG_W-1:0];
            set_size(wreg, hreg);
            area = sb.plane_width() * sb.plane_height();
            planes = $urandom_range(1, 4);
            for (int p = 0; p < planes && sent < goal; p++)
            begin
                case ($urandom_range(0, 9))
                    0: mode = PLANE_CUT;
                    1: mode = PLANE_NO_MARK;
                    default: mode = PLANE_CLEAN;
                endcase
                if (p == 0 && mode == PLANE_NO_MARK)
                    mode = PLANE_CLEAN;
                case ($urandom_range(0, 5))
                    0: fill = FILL_EXTREME;
                    1: fill = FILL_RAILS;
                    default: fill = FILL_RANDOM;
                endcase
                count = (mode == PLANE_CUT) ? int'($urandom_range(1, area - 1)) : area;
                quiet = ($urandom_range(0, 3) == 0);
                calm = (sent >= goal - CALM_TAIL);
                if (!calm && $urandom_range(0, 5) == 0)
                    wait_drained();
                send_run(count, mode != PLANE_NO_MARK, fill);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() > 0)
            sb.flag($sformatf("%0d output pixels never arrived", sb.pending()));
        if (sb.fails == 0)
            $display("bicubic_half_downscaler test passed");
        else
            $display("bicubic_half_downscaler test failed");
        $finish;
    end

endmodule
